[sv/cesm_pkg.sv]
`default_nettype none
package cesm_pkg;

  // counts of per-bus statistics
  localparam int NTOT  = 7;
  localparam int NWIN  = 6;
  localparam int NPEAK = 4;

  // divider widths
  localparam int DIV_W   = 48;
  localparam int DIV_BPS = 4;

  // last error codes
  localparam logic [2:0] LEC_STUFF = 3'd1;
  localparam logic [2:0] LEC_FORM  = 3'd2;
  localparam logic [2:0] LEC_ACK   = 3'd3;
  localparam logic [2:0] LEC_BIT1  = 3'd4;
  localparam logic [2:0] LEC_BIT0  = 3'd5;
  localparam logic [2:0] LEC_CRC   = 3'd6;

  // record identifiers
  localparam logic [4:0] ID_PERR      = 5'd0;
  localparam logic [4:0] ID_ERR_DELTA = 5'd7;
  localparam logic [4:0] ID_RX_DELTA  = 5'd8;
  localparam logic [4:0] ID_TX_DELTA  = 5'd9;
  localparam logic [4:0] ID_LOG_DELTA = 5'd10;
  localparam logic [4:0] ID_AVG0      = 5'd11;
  localparam logic [4:0] ID_PEAK0     = 5'd17;
  localparam logic [4:0] ID_LAST      = 5'd20;

  // one slot of the history ring
  typedef struct packed {
    logic [7:0]  cel_d;
    logic [31:0] err_d;
    logic [31:0] rx_d;
    logic [31:0] tx_d;
    logic [7:0]  tec;
    logic [6:0]  rec;
  } ring_word_t;

  localparam int RING_W = $bits(ring_word_t);

endpackage
`default_nettype wire

[sv/can_error_statistics_monitor.sv]
// Flow: an input transfer is captured in IDLE; CALC registers totals and deltas, RD
// writes the history slot and slides the window (skipped with the window off). Records
// then leave from EMIT one per cycle while the output does not stall; each of the six
// averages waits in DIVW on the shared 4-bit-per-cycle divider. The input stalls until IDLE.
// Reset (synchronous) clears all per-bus state and sets the window to 256; the history
// memory is not cleared, its slots are masked by the fill count until written.
`default_nettype none
module can_error_statistics_monitor #(
  parameter int BUSES      = 2,
  parameter int HIST_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        bus,
  input  wire logic [7:0]  tx_err_count,
  input  wire logic [6:0]  rx_err_count,
  input  wire logic [7:0]  err_log_count,
  input  wire logic [2:0]  last_err_code,
  input  wire logic        protocol_error,
  input  wire logic        log_overflow,
  input  wire logic [6:0]  fifo0_level,
  input  wire logic [6:0]  fifo1_level,
  input  wire logic [31:0] rx_total,
  input  wire logic [31:0] tx_total,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_bus,
  output logic [4:0]       stat_id,
  output logic [47:0]      stat_value,
  output logic             last
);

  localparam int BW  = (BUSES > 1) ? $clog2(BUSES) : 1;
  localparam int HW  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FW  = $clog2(HIST_DEPTH + 1);
  localparam int RD  = BUSES * (2 ** HW);
  localparam int RING_AW = (RD > 1) ? $clog2(RD) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;

  logic [2:0] state;

  // configuration and per-bus state
  logic [8:0]  win_cfg;
  logic [7:0]  prev_log [BUSES];
  logic [31:0] prev_err [BUSES];
  logic [31:0] prev_rx  [BUSES];
  logic [31:0] prev_tx  [BUSES];
  logic [31:0] totals   [BUSES][cesm_pkg::NTOT];
  logic [39:0] sums     [BUSES][cesm_pkg::NWIN];
  logic [HW-1:0] head   [BUSES];
  logic [FW-1:0] fill   [BUSES];
  logic [7:0]  peaks    [BUSES][cesm_pkg::NPEAK];

  // captured snapshot
  logic [BW-1:0] b_r;
  logic        bus_r;
  logic [7:0]  tec_r;
  logic [6:0]  rec_r;
  logic [7:0]  cel_r;
  logic [2:0]  lec_r;
  logic        perr_r;
  logic        lovf_r;
  logic [6:0]  f0_r;
  logic [6:0]  f1_r;
  logic [31:0] rxt_r;
  logic [31:0] txt_r;

  // deltas and sequencing
  logic [7:0]  cel_d_r;
  logic [31:0] err_d_r;
  logic [31:0] rx_d_r;
  logic [31:0] tx_d_r;
  logic [4:0]  idx;
  logic        q_ready;

  logic [FW-1:0] w_eff;
  logic          win_on;
  logic [7:0]    cel_prev;
  logic [7:0]    cel_d;
  logic [31:0]   tot_n [cesm_pkg::NTOT];
  logic [RING_AW-1:0] ram_addr;
  logic [cesm_pkg::RING_W-1:0] ram_rdata;
  cesm_pkg::ring_word_t wr_word;
  cesm_pkg::ring_word_t old_word;
  logic [31:0] vals [cesm_pkg::NWIN];
  logic [31:0] olds [cesm_pkg::NWIN];
  logic [FW-1:0] hp1;
  logic          ram_we;

  logic          rec_avg;
  logic          rec_last;
  logic [47:0]   rec_val;
  logic [2:0]    win_i;
  logic [1:0]    peak_i;
  logic          out_free;
  logic          div_start;
  logic [47:0]   div_q;
  logic          div_done;
  logic          load;

  // effective window, saturated to the history depth
  always_comb begin
    if (32'(win_cfg) > 32'(HIST_DEPTH)) begin
      w_eff = FW'(HIST_DEPTH);
    end else begin
      w_eff = FW'(win_cfg);
    end
  end
  assign win_on = (win_cfg != 9'd0);

  // totals and logging delta for the captured bus
  always_comb begin
    cel_prev = prev_log[b_r];
    cel_d    = (cel_r >= cel_prev) ? cel_r - cel_prev : cel_r;
    for (int i = 0; i < cesm_pkg::NTOT; i++) begin
      tot_n[i] = totals[b_r][i];
    end
    tot_n[0] = totals[b_r][0] + 32'(perr_r);
    tot_n[1] = totals[b_r][1] + 32'(lovf_r);
    tot_n[2] = totals[b_r][2] + 32'(cel_d);
    case (lec_r)
      cesm_pkg::LEC_ACK:                      tot_n[3] = totals[b_r][3] + 32'd1;
      cesm_pkg::LEC_STUFF, cesm_pkg::LEC_FORM: tot_n[4] = totals[b_r][4] + 32'd1;
      cesm_pkg::LEC_BIT1, cesm_pkg::LEC_BIT0:  tot_n[5] = totals[b_r][5] + 32'd1;
      cesm_pkg::LEC_CRC:                      tot_n[6] = totals[b_r][6] + 32'd1;
      default: ;
    endcase
  end

  // history slot write and old value
  assign ram_addr = RING_AW'({b_r, head[b_r]});
  assign ram_we   = (state == S_RD);
  assign wr_word  = '{cel_d: cel_d_r, err_d: err_d_r, rx_d: rx_d_r, tx_d: tx_d_r,
                      tec: tec_r, rec: rec_r};
  assign old_word = (fill[b_r] < w_eff) ? '0 : cesm_pkg::ring_word_t'(ram_rdata);
  assign hp1      = FW'(head[b_r]) + FW'(1);

  always_comb begin
    vals[0] = 32'(wr_word.cel_d);
    vals[1] = wr_word.err_d;
    vals[2] = wr_word.rx_d;
    vals[3] = wr_word.tx_d;
    vals[4] = 32'(wr_word.tec);
    vals[5] = 32'(wr_word.rec);
    olds[0] = 32'(old_word.cel_d);
    olds[1] = old_word.err_d;
    olds[2] = old_word.rx_d;
    olds[3] = old_word.tx_d;
    olds[4] = 32'(old_word.tec);
    olds[5] = 32'(old_word.rec);
  end

  cesm_ram #(
    .W     (cesm_pkg::RING_W),
    .DEPTH (RD)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (wr_word),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // record value selection
  assign win_i    = 3'(idx - cesm_pkg::ID_AVG0);
  assign peak_i   = 2'(idx - cesm_pkg::ID_PEAK0);
  assign rec_avg  = (idx >= cesm_pkg::ID_AVG0) && (idx < cesm_pkg::ID_PEAK0);
  assign rec_last = (idx == cesm_pkg::ID_LAST) || (idx == cesm_pkg::ID_LOG_DELTA && !win_on);

  always_comb begin
    if (idx < cesm_pkg::ID_ERR_DELTA) begin
      rec_val = 48'(totals[b_r][idx[2:0]]);
    end else if (idx == cesm_pkg::ID_ERR_DELTA) begin
      rec_val = 48'(err_d_r);
    end else if (idx == cesm_pkg::ID_RX_DELTA) begin
      rec_val = 48'(rx_d_r);
    end else if (idx == cesm_pkg::ID_TX_DELTA) begin
      rec_val = 48'(tx_d_r);
    end else if (idx == cesm_pkg::ID_LOG_DELTA) begin
      rec_val = 48'(cel_d_r);
    end else if (rec_avg) begin
      rec_val = div_q;
    end else begin
      rec_val = 48'(peaks[b_r][peak_i]);
    end
  end

  // shared divider for the averages
  assign div_start = (state == S_EMIT) && rec_avg && !q_ready;

  cesm_div #(
    .VW (FW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sums[b_r][win_i], 8'd0}),
    .divisor  (fill[b_r]),
    .quotient (div_q),
    .done     (div_done)
  );

  // handshakes
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign load      = (state == S_EMIT) && out_free && !(rec_avg && !q_ready);

  // sequencer and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      win_cfg     <= 9'd256;
      out_valid   <= 1'b0;
      q_ready     <= 1'b0;
      idx         <= '0;
      for (int b = 0; b < BUSES; b++) begin
        prev_log[b] <= '0;
        prev_err[b] <= '0;
        prev_rx[b]  <= '0;
        prev_tx[b]  <= '0;
        head[b]     <= '0;
        fill[b]     <= '0;
        for (int i = 0; i < cesm_pkg::NTOT; i++) begin
          totals[b][i] <= '0;
        end
        for (int i = 0; i < cesm_pkg::NWIN; i++) begin
          sums[b][i] <= '0;
        end
        for (int i = 0; i < cesm_pkg::NPEAK; i++) begin
          peaks[b][i] <= '0;
        end
      end
    end else begin
      // output register drains
      if (load) begin
        out_valid  <= 1'b1;
        out_bus    <= bus_r;
        stat_id    <= idx;
        stat_value <= rec_val;
        last       <= rec_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          // window register write clears the window state
          if (cfg_valid) begin
            win_cfg <= cfg_data;
            for (int b = 0; b < BUSES; b++) begin
              head[b] <= '0;
              fill[b] <= '0;
              for (int i = 0; i < cesm_pkg::NWIN; i++) begin
                sums[b][i] <= '0;
              end
            end
          end
          if (in_valid) begin
            b_r    <= BW'(bus);
            bus_r  <= bus;
            tec_r  <= tx_err_count;
            rec_r  <= rx_err_count;
            cel_r  <= err_log_count;
            lec_r  <= last_err_code;
            perr_r <= protocol_error;
            lovf_r <= log_overflow;
            f0_r   <= fifo0_level;
            f1_r   <= fifo1_level;
            rxt_r  <= rx_total;
            txt_r  <= tx_total;
            if (32'(bus) < 32'(BUSES)) begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          // totals, deltas and previous values
          for (int i = 0; i < cesm_pkg::NTOT; i++) begin
            totals[b_r][i] <= tot_n[i];
          end
          cel_d_r       <= cel_d;
          err_d_r       <= tot_n[0] - prev_err[b_r];
          rx_d_r        <= rxt_r - prev_rx[b_r];
          tx_d_r        <= txt_r - prev_tx[b_r];
          prev_log[b_r] <= cel_r;
          prev_err[b_r] <= tot_n[0];
          prev_rx[b_r]  <= rxt_r;
          prev_tx[b_r]  <= txt_r;
          idx           <= cesm_pkg::ID_PERR;
          q_ready       <= 1'b0;
          state         <= win_on ? S_RD : S_EMIT;
        end
        S_RD: begin
          // slide the window and track peaks
          for (int i = 0; i < cesm_pkg::NWIN; i++) begin
            sums[b_r][i] <= sums[b_r][i] + 40'(vals[i]) - 40'(olds[i]);
          end
          head[b_r] <= (hp1 == w_eff) ? '0 : HW'(hp1);
          if (fill[b_r] < w_eff) begin
            fill[b_r] <= fill[b_r] + FW'(1);
          end
          if (tec_r > peaks[b_r][0]) peaks[b_r][0] <= tec_r;
          if ({1'b0, rec_r} > peaks[b_r][1]) peaks[b_r][1] <= {1'b0, rec_r};
          if (cel_d_r > peaks[b_r][2]) peaks[b_r][2] <= cel_d_r;
          if ({1'b0, f0_r} >= {1'b0, f1_r}) begin
            if ({1'b0, f0_r} > peaks[b_r][3]) peaks[b_r][3] <= {1'b0, f0_r};
          end else begin
            if ({1'b0, f1_r} > peaks[b_r][3]) peaks[b_r][3] <= {1'b0, f1_r};
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (div_start) begin
            state <= S_DIVW;
          end else if (load) begin
            idx     <= idx + 5'd1;
            q_ready <= 1'b0;
            if (rec_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_DIVW: begin
          if (div_done) begin
            q_ready <= 1'b1;
            state   <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/cesm_ram.sv]
`default_nettype none
module cesm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                           wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                                rdata
);

  logic [W-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/cesm_div.sv]
`default_nettype none
module cesm_div #(
  parameter int VW = 9
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [cesm_pkg::DIV_W-1:0] dividend,
  input  wire logic [VW-1:0]             divisor,
  output logic [cesm_pkg::DIV_W-1:0]     quotient,
  output logic                           done
);

  localparam int STEPS = cesm_pkg::DIV_W / cesm_pkg::DIV_BPS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [VW-1:0]                rem;
  logic [VW-1:0]                dv;
  logic [CW-1:0]                cnt;
  logic                         busy;
  logic [VW-1:0]                rem_next;
  logic [cesm_pkg::DIV_W-1:0]   quo_next;

  // four restoring steps per cycle
  always_comb begin
    logic [VW:0]                t;
    logic [VW-1:0]              r;
    logic [cesm_pkg::DIV_W-1:0] q;
    r = rem;
    q = quotient;
    for (int k = 0; k < cesm_pkg::DIV_BPS; k++) begin
      t = {r, q[cesm_pkg::DIV_W-1]};
      q = {q[cesm_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        t = t - {1'b0, dv};
        q[0] = 1'b1;
      end
      r = t[VW-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CW'(STEPS);
        rem      <= '0;
        dv       <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= rem_next;
        quotient <= quo_next;
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[sv/cesm_check.sv]
`default_nettype none
module cesm_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        bus,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  stat_id,
  input wire logic [47:0] stat_value,
  input wire logic        last
);

  // a stalled record stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(stat_value) && $stable(stat_id))
    else $error("stalled record changed");

  // bus 0 is always served, so the input stalls after its transfer
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !bus |=> in_stall)
    else $error("input not stalled after transfer");

  // identifiers stay within the record set
  a_id_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stat_id <= cesm_pkg::ID_LAST)
    else $error("record identifier out of range");

  // the closing flag only on the final record
  a_last_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (stat_id == cesm_pkg::ID_LOG_DELTA || stat_id == cesm_pkg::ID_LAST))
    else $error("last flag on wrong record");

  // the input is not taken while the previous snapshot is still being emitted
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input taken mid snapshot");

endmodule

bind can_error_statistics_monitor cesm_check u_cesm_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .bus        (bus),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .stat_id    (stat_id),
  .stat_value (stat_value),
  .last       (last)
);
`default_nettype wire

[verif/tb_can_error_statistics_monitor.sv]
`timescale 1ns / 100ps
module tb_can_error_statistics_monitor;

  localparam int BUS_N    = 2;
  localparam int DEPTH    = 256;
  localparam int SETTLE   = 120;
  localparam int LIMIT    = 1500000;

  typedef struct {
    logic        bus;
    logic [7:0]  tec;
    logic [6:0]  rec;
    logic [7:0]  cel;
    logic [2:0]  lec;
    logic        perr;
    logic        lovf;
    logic [6:0]  f0;
    logic [6:0]  f1;
    logic [31:0] rxt;
    logic [31:0] txt;
  } snapshot_t;

  typedef struct {
    logic        bus;
    logic [4:0]  id;
    logic [47:0] value;
    logic        last;
  } stat_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        bus = 1'b0;
  logic [7:0]  tx_err_count = '0;
  logic [6:0]  rx_err_count = '0;
  logic [7:0]  err_log_count = '0;
  logic [2:0]  last_err_code = '0;
  logic        protocol_error = 1'b0;
  logic        log_overflow = 1'b0;
  logic [6:0]  fifo0_level = '0;
  logic [6:0]  fifo1_level = '0;
  logic [31:0] rx_total = '0;
  logic [31:0] tx_total = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_bus;
  logic [4:0]  stat_id;
  logic [47:0] stat_value;
  logic        last;

  can_error_statistics_monitor dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .bus(bus),
    .tx_err_count(tx_err_count), .rx_err_count(rx_err_count),
    .err_log_count(err_log_count), .last_err_code(last_err_code),
    .protocol_error(protocol_error), .log_overflow(log_overflow),
    .fifo0_level(fifo0_level), .fifo1_level(fifo1_level),
    .rx_total(rx_total), .tx_total(tx_total),
    .out_valid(out_valid), .out_stall(out_stall), .out_bus(out_bus),
    .stat_id(stat_id), .stat_value(stat_value), .last(last)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted state of the block
  int unsigned  win_len;
  logic [7:0]   p_log   [BUS_N];
  logic [31:0]  p_err   [BUS_N];
  logic [31:0]  p_rx    [BUS_N];
  logic [31:0]  p_tx    [BUS_N];
  logic [31:0]  evt_tot [BUS_N][cesm_pkg::NTOT];
  logic [39:0]  win_sum [BUS_N][cesm_pkg::NWIN];
  logic [31:0]  hist    [BUS_N][DEPTH][cesm_pkg::NWIN];
  int unsigned  head_ix [BUS_N];
  int unsigned  fill_n  [BUS_N];
  logic [7:0]   peak    [BUS_N][cesm_pkg::NPEAK];

  stat_rec_t    pending_stats[$];
  bit           failed = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_req = 0;
  int           hold_left = 0;
  longint       cycles = 0;

  // generator tracking for well-formed sequences
  logic [7:0]   g_log [BUS_N];
  logic [31:0]  g_rx  [BUS_N];
  logic [31:0]  g_tx  [BUS_N];

  task automatic clear_window_state();
    for (int b = 0; b < BUS_N; b++) begin
      head_ix[b] = 0;
      fill_n[b] = 0;
      for (int i = 0; i < cesm_pkg::NWIN; i++) begin
        win_sum[b][i] = '0;
        for (int d = 0; d < DEPTH; d++) hist[b][d][i] = '0;
      end
    end
  endtask

  task automatic reset_prediction();
    win_len = 256;
    for (int b = 0; b < BUS_N; b++) begin
      p_log[b] = '0; p_err[b] = '0; p_rx[b] = '0; p_tx[b] = '0;
      g_log[b] = '0; g_rx[b] = '0; g_tx[b] = '0;
      for (int k = 0; k < cesm_pkg::NTOT; k++) evt_tot[b][k] = '0;
      for (int k = 0; k < cesm_pkg::NPEAK; k++) peak[b][k] = '0;
    end
    clear_window_state();
  endtask

  task automatic push_stat(logic b, int id, logic [47:0] v, logic lst);
    stat_rec_t r;
    r.bus = b; r.id = id[4:0]; r.value = v; r.last = lst;
    pending_stats.push_back(r);
  endtask

  // works out the records of one accepted snapshot
  task automatic predict_snapshot(snapshot_t s);
    int          b;
    logic [31:0] cel_d, err_d, rx_d, tx_d;
    logic [31:0] vals[cesm_pkg::NWIN];
    logic [63:0] acc;
    int unsigned w, hd;
    b = int'(s.bus);
    if (s.perr) evt_tot[b][0] = evt_tot[b][0] + 1;
    if (s.lovf) evt_tot[b][1] = evt_tot[b][1] + 1;
    cel_d = (s.cel >= p_log[b]) ? 32'(s.cel - p_log[b]) : 32'(s.cel);
    p_log[b] = s.cel;
    evt_tot[b][2] = evt_tot[b][2] + cel_d;
    case (s.lec)
      cesm_pkg::LEC_ACK:                       evt_tot[b][3] = evt_tot[b][3] + 1;
      cesm_pkg::LEC_STUFF, cesm_pkg::LEC_FORM: evt_tot[b][4] = evt_tot[b][4] + 1;
      cesm_pkg::LEC_BIT1, cesm_pkg::LEC_BIT0:  evt_tot[b][5] = evt_tot[b][5] + 1;
      cesm_pkg::LEC_CRC:                       evt_tot[b][6] = evt_tot[b][6] + 1;
      default: ;
    endcase
    err_d = evt_tot[b][0] - p_err[b];
    p_err[b] = evt_tot[b][0];
    rx_d = s.rxt - p_rx[b];
    p_rx[b] = s.rxt;
    tx_d = s.txt - p_tx[b];
    p_tx[b] = s.txt;
    for (int k = 0; k < cesm_pkg::NTOT; k++)
      push_stat(s.bus, k, 48'(evt_tot[b][k]), 1'b0);
    push_stat(s.bus, cesm_pkg::ID_ERR_DELTA, 48'(err_d), 1'b0);
    push_stat(s.bus, cesm_pkg::ID_RX_DELTA, 48'(rx_d), 1'b0);
    push_stat(s.bus, cesm_pkg::ID_TX_DELTA, 48'(tx_d), 1'b0);
    // window off: deltas are the final records
    if (win_len == 0) begin
      push_stat(s.bus, cesm_pkg::ID_LOG_DELTA, 48'(cel_d), 1'b1);
    end else begin
      push_stat(s.bus, cesm_pkg::ID_LOG_DELTA, 48'(cel_d), 1'b0);
      w = (win_len > DEPTH) ? DEPTH : win_len;
      vals[0] = cel_d; vals[1] = err_d; vals[2] = rx_d; vals[3] = tx_d;
      vals[4] = 32'(s.tec); vals[5] = 32'(s.rec);
      hd = head_ix[b];
      if (hd >= DEPTH) hd = 0;
      for (int i = 0; i < cesm_pkg::NWIN; i++) begin
        acc = 64'(win_sum[b][i]) + 64'(vals[i]) - 64'(hist[b][hd][i]);
        win_sum[b][i] = acc[39:0];
        hist[b][hd][i] = vals[i];
      end
      head_ix[b] = (hd + 1) % w;
      if (fill_n[b] < w) fill_n[b] = fill_n[b] + 1;
      for (int i = 0; i < cesm_pkg::NWIN; i++) begin
        acc = (64'(win_sum[b][i]) << 8) / 64'(fill_n[b]);
        push_stat(s.bus, cesm_pkg::ID_AVG0 + i, acc[47:0], 1'b0);
      end
      if (s.tec > peak[b][0]) peak[b][0] = s.tec;
      if (8'(s.rec) > peak[b][1]) peak[b][1] = 8'(s.rec);
      if (cel_d > 32'(peak[b][2])) peak[b][2] = cel_d[7:0];
      if (8'(s.f0) > peak[b][3]) peak[b][3] = 8'(s.f0);
      if (8'(s.f1) > peak[b][3]) peak[b][3] = 8'(s.f1);
      for (int k = 0; k < cesm_pkg::NPEAK; k++)
        push_stat(s.bus, cesm_pkg::ID_PEAK0 + k, 48'(peak[b][k]),
                  (k == cesm_pkg::NPEAK - 1));
    end
  endtask

  // one snapshot transfer; called and returns just after a falling edge
  task automatic send_snapshot(snapshot_t s);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    bus <= s.bus; tx_err_count <= s.tec; rx_err_count <= s.rec;
    err_log_count <= s.cel; last_err_code <= s.lec;
    protocol_error <= s.perr; log_overflow <= s.lovf;
    fifo0_level <= s.f0; fifo1_level <= s.f1;
    rx_total <= s.rxt; tx_total <= s.txt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_snapshot(s);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_stats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // register write, only once the block has drained
  task automatic write_window(int unsigned v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_len = v & 9'h1FF;
    clear_window_state();
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic snapshot_t make_snapshot(logic b, logic [7:0] tec, logic [6:0] rec,
                                              logic [7:0] cel, logic [2:0] lec,
                                              logic perr, logic lovf, logic [6:0] f0,
                                              logic [6:0] f1, logic [31:0] rxt,
                                              logic [31:0] txt);
    snapshot_t s;
    s.bus = b; s.tec = tec; s.rec = rec; s.cel = cel; s.lec = lec;
    s.perr = perr; s.lovf = lovf; s.f0 = f0; s.f1 = f1; s.rxt = rxt; s.txt = txt;
    return s;
  endfunction

  // mostly climbing counters, some noise
  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    int b;
    b = $urandom_range(1);
    s.bus = b[0];
    s.tec = 8'($urandom_range(255));
    s.rec = 7'($urandom_range(127));
    s.lec = 3'($urandom_range(7));
    s.perr = 1'($urandom_range(1));
    s.lovf = ($urandom_range(3) == 0);
    s.f0 = 7'($urandom_range(64));
    s.f1 = 7'($urandom_range(64));
    if ($urandom_range(99) < 80) begin
      g_log[b] = (g_log[b] > 250) ? 8'd255 : g_log[b] + 8'($urandom_range(4));
      if ($urandom_range(30) == 0) g_log[b] = 8'($urandom_range(20));
      g_rx[b] = g_rx[b] + $urandom_range(2000);
      g_tx[b] = g_tx[b] + $urandom_range(2000);
      s.cel = g_log[b]; s.rxt = g_rx[b]; s.txt = g_tx[b];
    end else begin
      s.cel = 8'($urandom_range(255));
      s.rxt = $urandom;
      s.txt = $urandom;
    end
    return s;
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_snapshot(random_snapshot());
  endtask

  // extremes, every error code, falling log count, wrapping totals
  task automatic test_directed();
    send_snapshot(make_snapshot(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_snapshot(make_snapshot(1, 255, 127, 255, 7, 1, 1, 64, 64, '1, '1));
    for (int c = 0; c < 8; c++)
      send_snapshot(make_snapshot(c[0], 8'(c * 30), 7'(c * 15), 8'(c * 20), c[2:0],
                                  c[1], c[2], 7'(c * 9), 7'(64 - c * 9),
                                  32'(c * 1000), 32'(c * 777)));
    send_snapshot(make_snapshot(0, 10, 5, 3, 3, 1, 0, 64, 0, 32'hFFFF_FFF0, 5));
    send_snapshot(make_snapshot(0, 255, 127, 200, 6, 1, 1, 0, 64, 32'h10, 0));
    send_snapshot(make_snapshot(1, 1, 1, 0, 1, 0, 1, 1, 1, 0, '1));
    send_snapshot(make_snapshot(1, 128, 64, 128, 5, 1, 0, 32, 33, 32'h8000_0000, 1));
  endtask

  task automatic test_window_settings();
    write_window(0);
    test_directed();
    send_random(20);
    write_window(1);
    send_random(20);
    write_window(3);
    send_random(25);
    write_window(511);
    send_random(20);
    write_window(300);
    send_random(15);
    write_window(255);
    send_random(15);
  endtask

  task automatic test_idle_phases();
    write_window(5);
    send_idle_pct = 73; recv_stall_pct = 0;
    send_random(60);
    write_window(2);
    send_idle_pct = 0; recv_stall_pct = 73;
    send_random(60);
    write_window(16);
    send_idle_pct = 8; recv_stall_pct = 8;
    send_random(60);
    write_window(0);
    send_random(30);
    send_idle_pct = 0; recv_stall_pct = 0;
    write_window(7);
    send_random(40);
  endtask

  // long receiver hold-off while snapshots keep coming
  task automatic test_back_pressure();
    write_window(4);
    hold_req = 1;
    send_random(30);
    write_window(256);
    send_random(20);
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 600;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // record checker
  always @(posedge clk) begin
    stat_rec_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected record bus %0d id %0d value %0h last %0b",
                 $time, out_bus, stat_id, stat_value, last);
        failed = 1;
      end else begin
        e = pending_stats.pop_front();
        if (out_bus !== e.bus || stat_id !== e.id || stat_value !== e.value ||
            last !== e.last) begin
          $display("%0t: mismatch expected bus %0d id %0d value %0h last %0b",
                   $time, e.bus, e.id, e.value, e.last);
          $display("%0t:          actual   bus %0d id %0d value %0h last %0b",
                   $time, out_bus, stat_id, stat_value, last);
          failed = 1;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > LIMIT) begin
      $display("can_error_statistics_monitor test failed");
      $finish;
    end
  end

  initial begin
    reset_prediction();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_window_settings();
    test_idle_phases();
    test_back_pressure();
    wait_idle();
    if (!failed && pending_stats.size() == 0) begin
      $display("can_error_statistics_monitor test passed");
    end else begin
      $display("can_error_statistics_monitor test failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/cesm_pkg.sv
sv/cesm_ram.sv
sv/cesm_div.sv
sv/can_error_statistics_monitor.sv
sv/cesm_check.sv
verif/tb_can_error_statistics_monitor.sv
